/* src/sorted_event_timer_queue_unit_macros.svh */
// assertion helpers
`ifndef SORTED_EVENT_TIMER_QUEUE_UNIT_MACROS_SVH
`define SORTED_EVENT_TIMER_QUEUE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SETQ_ASSERT(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`define SETQ_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`else
`define SETQ_ASSERT(name, cond, msg)
`define SETQ_ASSERT_NEXT(name, pre, post, msg)
`endif
`endif

/* src/setq_pkg.sv */
package setq_pkg;

   localparam int MAX_RESULTS = 16;
   localparam int EV_IDX_BITS = 4;
   localparam int NEV_BITS    = 5;

   typedef enum logic [3:0] {
      CMD_SET      = 4'd0,
      CMD_RESET    = 4'd1,
      CMD_RESET_IV = 4'd2,
      CMD_RESTART  = 4'd3,
      CMD_ADJUST   = 4'd4,
      CMD_STOP     = 4'd5,
      CMD_POLL     = 4'd6,
      CMD_EXITED   = 4'd7,
      CMD_QUERY    = 4'd8
   } cmd_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_STOP,
      ST_EXPIRY,
      ST_INSERT,
      ST_POLL,
      ST_OWNER,
      ST_STATUS,
      ST_OUT
   } state_type;

endpackage

/* src/sorted_event_timer_queue_unit.sv */
// channel  | valid     | stall     | fields
// request  | req_valid | req_stall | command slot owner now interval time_shift sink_space
// response | rsp_valid | rsp_stall | event_valid event_slot event_owner last poll_request
//          |           |           | pending next_expiration slot_idle
// One word in flight at a time; req_stall is high from acceptance until the last response
// word is taken. The insert and poll list walks use the shared adder; each list walk (stop,
// insert, poll, owner exit) handles one list entry per cycle.
// Reset is synchronous and clears all slots and the list; no clearing pass is needed.
`include "sorted_event_timer_queue_unit_macros.svh"
module sorted_event_timer_queue_unit #(
   parameter int SLOTS     = 16,
   parameter int TIME_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_command,
   input  logic [3:0]         req_slot,
   input  logic [7:0]         req_owner,
   input  logic [31:0]        req_now,
   input  logic [31:0]        req_interval,
   input  logic signed [31:0] req_time_shift,
   input  logic [4:0]         req_sink_space,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_event_valid,
   output logic [3:0]         rsp_event_slot,
   output logic [7:0]         rsp_event_owner,
   output logic               rsp_last,
   output logic               rsp_poll_request,
   output logic               rsp_pending,
   output logic [31:0]        rsp_next_expiration,
   output logic               rsp_slot_idle
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int TB = TIME_BITS;

   typedef logic [setq_pkg::NEV_BITS-1:0] nev_type;

   setq_pkg::state_type state_ff, state_in;

   logic [3:0]    cmd_ff, cmd_in;
   logic [3:0]    slot_ff, slot_in;
   logic [7:0]    owner_ff, owner_in;
   logic [TB-1:0] now_ff, now_in;
   logic [TB-1:0] ival_ff, ival_in;
   logic [TB-1:0] shift_ff, shift_in;
   logic [4:0]    space_ff, space_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [setq_pkg::NEV_BITS-1:0]    nev_ff, nev_in;
   logic [setq_pkg::EV_IDX_BITS-1:0] k_ff, k_in;
   logic          preq_ff, preq_in;
   logic          idle_ff, idle_in;
   logic [TB-1:0] e_ff, e_in;
   logic [TB-1:0] nexp_ff, nexp_in;
   logic [SLOTS-1:0] active_ff, active_in;
   logic [SW-1:0] order_ff [SLOTS];
   logic [SW-1:0] order_in [SLOTS];
   logic [TB-1:0] start_ff [SLOTS];
   logic [TB-1:0] start_in [SLOTS];
   logic [TB-1:0] period_ff [SLOTS];
   logic [TB-1:0] period_in [SLOTS];
   logic [TB-1:0] exp_ff [SLOTS];
   logic [TB-1:0] exp_in [SLOTS];
   logic [7:0]    otab_ff [SLOTS];
   logic [7:0]    otab_in [SLOTS];
   logic [SW-1:0] evs_ff [setq_pkg::MAX_RESULTS];
   logic [SW-1:0] evs_in [setq_pkg::MAX_RESULTS];
   logic [7:0]    evo_ff [setq_pkg::MAX_RESULTS];
   logic [7:0]    evo_in [setq_pkg::MAX_RESULTS];

   logic          slot_valid, is_ins, is_stop, in_range, earlier, last;
   logic [SW-1:0] sl, cur;
   setq_pkg::alu_op_type alu_op;
   logic [TB-1:0] alu_a, alu_b, alu_c, alu_res;
   logic          alu_ge;

   setq_alu #(.TIME_BITS(TB)) u_alu (
      .op(alu_op), .a(alu_a), .b(alu_b), .c(alu_c), .res(alu_res), .ge(alu_ge)
   );

   always_comb begin
      sl         = SW'(slot_ff);
      slot_valid = (32'(slot_ff) < SLOTS);
      is_ins     = slot_valid && ((cmd_ff == setq_pkg::CMD_SET)
                   || (cmd_ff == setq_pkg::CMD_RESET) || (cmd_ff == setq_pkg::CMD_RESET_IV)
                   || (cmd_ff == setq_pkg::CMD_RESTART) || (cmd_ff == setq_pkg::CMD_ADJUST));
      is_stop    = slot_valid && (cmd_ff == setq_pkg::CMD_STOP);
      in_range   = (idx_ff < count_ff);
      cur        = order_ff[idx_ff[SW-1:0]];
      earlier    = alu_res[TB-1];
      last       = (nev_ff == '0) || ((nev_type'(k_ff) + 1'b1) == nev_ff);
   end

   always_comb begin
      alu_op = setq_pkg::ALU_ADD;
      alu_a  = start_ff[sl];
      alu_b  = period_ff[sl];
      alu_c  = period_ff[cur];
      unique case (state_ff)
         setq_pkg::ST_UPDATE: begin
            if (cmd_ff == setq_pkg::CMD_ADJUST) begin
               alu_b = shift_ff;
            end
         end
         setq_pkg::ST_INSERT: begin
            alu_op = setq_pkg::ALU_SUB;
            alu_a  = exp_ff[cur];
            alu_b  = e_ff;
         end
         setq_pkg::ST_POLL: begin
            alu_op = setq_pkg::ALU_SUB;
            alu_a  = now_ff;
            alu_b  = start_ff[cur];
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         setq_pkg::ST_IDLE: begin
            if (req_valid) state_in = setq_pkg::ST_UPDATE;
         end
         setq_pkg::ST_UPDATE: begin
            if (is_ins || is_stop) state_in = setq_pkg::ST_STOP;
            else if (cmd_ff == setq_pkg::CMD_POLL) state_in = setq_pkg::ST_POLL;
            else if (cmd_ff == setq_pkg::CMD_EXITED) state_in = setq_pkg::ST_OWNER;
            else state_in = setq_pkg::ST_STATUS;
         end
         setq_pkg::ST_STOP: begin
            if (!active_ff[sl] || !in_range || (cur == sl)) begin
               state_in = is_ins ? setq_pkg::ST_EXPIRY : setq_pkg::ST_STATUS;
            end
         end
         setq_pkg::ST_EXPIRY: state_in = setq_pkg::ST_INSERT;
         setq_pkg::ST_INSERT: begin
            if (!(in_range && earlier)) state_in = setq_pkg::ST_STATUS;
         end
         setq_pkg::ST_POLL: begin
            if (!in_range || !alu_ge) state_in = setq_pkg::ST_STATUS;
         end
         setq_pkg::ST_OWNER: begin
            if (!in_range) state_in = setq_pkg::ST_STATUS;
         end
         setq_pkg::ST_STATUS: state_in = setq_pkg::ST_OUT;
         setq_pkg::ST_OUT: begin
            if (!rsp_stall && last) state_in = setq_pkg::ST_IDLE;
         end
         default: state_in = setq_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      logic          unl;
      logic          ins;
      logic [CW-1:0] pos;
      unl       = 1'b0;
      ins       = 1'b0;
      pos       = idx_ff;
      cmd_in    = cmd_ff;
      slot_in   = slot_ff;
      owner_in  = owner_ff;
      now_in    = now_ff;
      ival_in   = ival_ff;
      shift_in  = shift_ff;
      space_in  = space_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      nev_in    = nev_ff;
      k_in      = k_ff;
      preq_in   = preq_ff;
      idle_in   = idle_ff;
      e_in      = e_ff;
      nexp_in   = nexp_ff;
      active_in = active_ff;
      order_in  = order_ff;
      start_in  = start_ff;
      period_in = period_ff;
      exp_in    = exp_ff;
      otab_in   = otab_ff;
      evs_in    = evs_ff;
      evo_in    = evo_ff;
      unique case (state_ff)
         setq_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               slot_in  = req_slot;
               owner_in = req_owner;
               now_in   = TB'(req_now);
               ival_in  = TB'(req_interval);
               shift_in = TB'(req_time_shift);
               space_in = req_sink_space;
               idx_in   = '0;
               nev_in   = '0;
               preq_in  = 1'b0;
            end
         end
         setq_pkg::ST_UPDATE: begin
            if (is_ins) begin
               unique case (cmd_ff)
                  setq_pkg::CMD_SET: begin
                     start_in[sl]  = now_ff;
                     period_in[sl] = ival_ff;
                  end
                  setq_pkg::CMD_RESET_IV: begin
                     start_in[sl]  = alu_res;
                     period_in[sl] = ival_ff;
                  end
                  setq_pkg::CMD_RESTART: start_in[sl] = now_ff;
                  default: start_in[sl] = alu_res;
               endcase
            end
         end
         setq_pkg::ST_STOP: begin
            if (active_ff[sl] && in_range) begin
               if (cur == sl) begin
                  unl    = 1'b1;
                  idx_in = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         setq_pkg::ST_EXPIRY: begin
            exp_in[sl] = alu_res;
            e_in       = alu_res;
         end
         setq_pkg::ST_INSERT: begin
            if (in_range && earlier) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               ins = 1'b1;
            end
         end
         setq_pkg::ST_POLL: begin
            if (in_range && alu_ge) begin
               if ((nev_ff < nev_type'(space_ff))
                     && (nev_ff < nev_type'(setq_pkg::MAX_RESULTS))) begin
                  evs_in[nev_ff[setq_pkg::EV_IDX_BITS-1:0]] = cur;
                  evo_in[nev_ff[setq_pkg::EV_IDX_BITS-1:0]] = otab_ff[cur];
                  nev_in = nev_ff + 1'b1;
                  unl    = 1'b1;
               end else begin
                  preq_in = 1'b1;
                  idx_in  = idx_ff + 1'b1;
               end
            end
         end
         setq_pkg::ST_OWNER: begin
            if (in_range) begin
               if (otab_ff[cur] == owner_ff) unl = 1'b1;
               else idx_in = idx_ff + 1'b1;
            end
         end
         setq_pkg::ST_STATUS: begin
            nexp_in = (count_ff != '0) ? exp_ff[order_ff[0]] : '0;
            idle_in = !(slot_valid && active_ff[sl]);
            k_in    = '0;
         end
         setq_pkg::ST_OUT: begin
            if (!rsp_stall && !last) k_in = k_ff + 1'b1;
         end
         default: begin
         end
      endcase
      if (unl) begin
         active_in[cur] = 1'b0;
         for (int i = 0; i < SLOTS - 1; i++) begin
            if (CW'(i) >= pos) order_in[i] = order_ff[i + 1];
         end
         count_in = count_ff - 1'b1;
      end
      if (ins) begin
         for (int i = 1; i < SLOTS; i++) begin
            if (CW'(i) > pos) order_in[i] = order_ff[i - 1];
         end
         order_in[pos[SW-1:0]] = sl;
         active_in[sl] = 1'b1;
         otab_in[sl]   = owner_ff;
         count_in      = count_ff + 1'b1;
         if (pos == '0) preq_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= setq_pkg::ST_IDLE;
         count_ff  <= '0;
         active_ff <= '0;
         idx_ff    <= '0;
         nev_ff    <= '0;
         k_ff      <= '0;
         preq_ff   <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            start_ff[i]  <= '0;
            period_ff[i] <= '0;
            otab_ff[i]   <= '0;
         end
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         active_ff <= active_in;
         idx_ff    <= idx_in;
         nev_ff    <= nev_in;
         k_ff      <= k_in;
         preq_ff   <= preq_in;
         start_ff  <= start_in;
         period_ff <= period_in;
         otab_ff   <= otab_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      slot_ff  <= slot_in;
      owner_ff <= owner_in;
      now_ff   <= now_in;
      ival_ff  <= ival_in;
      shift_ff <= shift_in;
      space_ff <= space_in;
      idle_ff  <= idle_in;
      e_ff     <= e_in;
      nexp_ff  <= nexp_in;
      order_ff <= order_in;
      exp_ff   <= exp_in;
      evs_ff   <= evs_in;
      evo_ff   <= evo_in;
   end

   assign req_stall           = (state_ff != setq_pkg::ST_IDLE);
   assign rsp_valid           = (state_ff == setq_pkg::ST_OUT);
   assign rsp_event_valid     = (nev_ff != '0);
   assign rsp_event_slot      = (nev_ff != '0) ? 4'(evs_ff[k_ff]) : 4'd0;
   assign rsp_event_owner     = (nev_ff != '0) ? evo_ff[k_ff] : 8'd0;
   assign rsp_last            = last;
   assign rsp_poll_request    = preq_ff;
   assign rsp_pending         = (count_ff != '0);
   assign rsp_next_expiration = 32'(nexp_ff);
   assign rsp_slot_idle       = idle_ff;

   `SETQ_ASSERT(a_count_bound, count_ff <= CW'(SLOTS), "active count beyond slot count")
   `SETQ_ASSERT(a_busy_stall, !rsp_valid || req_stall, "request taken while words pending")
   `SETQ_ASSERT(a_nev_bound, nev_ff <= nev_type'(setq_pkg::MAX_RESULTS), "too many events")
   `SETQ_ASSERT_NEXT(a_done, rsp_valid && !rsp_stall && rsp_last, !req_stall, "no return to idle")

endmodule

/* src/setq_alu.sv */
module setq_alu #(
   parameter int TIME_BITS = 32
) (
   input  setq_pkg::alu_op_type op,
   input  logic [TIME_BITS-1:0] a,
   input  logic [TIME_BITS-1:0] b,
   input  logic [TIME_BITS-1:0] c,
   output logic [TIME_BITS-1:0] res,
   output logic                 ge
);

   always_comb begin
      unique case (op)
         setq_pkg::ALU_ADD: res = a + b;
         setq_pkg::ALU_SUB: res = a - b;
         default:           res = a - b;
      endcase
      ge = (res >= c);
   end

endmodule
